// ===== hdl/ostb_pkg.sv =====
// Shared constants, operation codes and sizes for the one-shot timer bank.
package ostb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int COUNT_BITS = 32;

  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MASK_N = (NUM_TIMERS < 8) ? NUM_TIMERS : 8;

  localparam int OP_W     = 3;
  localparam int INDEX_W  = 3;
  localparam int TARGET_W = 32;
  localparam int ELAPSE_W = 32;
  localparam int MASK_W   = 8;

  typedef logic [OP_W-1:0]       op_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0]      tidx_t;

  localparam op_t OP_TICK      = 3'd0;
  localparam op_t OP_ARM       = 3'd1;
  localparam op_t OP_CLR_ENTRY = 3'd2;
  localparam op_t OP_CLR_ALL   = 3'd3;
  localparam op_t OP_CLR_TO    = 3'd4;
  localparam op_t OP_QUERY     = 3'd5;

endpackage

// ===== hdl/one_shot_timer_bank.sv =====
// One-shot timer bank: per-timer count/target store, sweep sequencer and result register.
// Sequence: an accepted item enters the step unit; tick and clear all step through every
//   timer in turn, while arm, clear entry, clear timeout and query act on the named timer.
// The result is then loaded into the output register once that register is free or draining.
// Items are handled one at a time, set by the single compare/increment unit.
// A finished result waits in the output register while the next item is taken in.
// Reset (rst_n low, synchronous) zeroes every count, target and mark and empties the output.
module one_shot_timer_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [2:0]  in_timer_index,
  input  logic [31:0] in_target_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_timeout_flag,
  output logic        out_running_flag,
  output logic [31:0] out_elapsed_count,
  output logic [7:0]  out_timeout_mask
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORK = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  localparam ostb_pkg::tidx_t LAST_IDX = ostb_pkg::tidx_t'(ostb_pkg::NUM_TIMERS - 1);

  // Timer store
  ostb_pkg::count_t cnt_r [ostb_pkg::NUM_TIMERS];
  ostb_pkg::count_t tgt_r [ostb_pkg::NUM_TIMERS];
  logic [ostb_pkg::NUM_TIMERS-1:0] exp_r;
  logic [ostb_pkg::NUM_TIMERS-1:0] act_r;

  // Sequencer and captured item
  logic [1:0]       state_r, state_nxt;
  ostb_pkg::tidx_t  ptr_r, ptr_nxt;
  ostb_pkg::op_t    op_r;
  ostb_pkg::tidx_t  sel_r;
  logic             idx_ok_r;
  ostb_pkg::count_t arm_tgt_r;

  // Output register
  logic        out_valid_r;
  logic        out_to_r;
  logic        out_run_r;
  logic [31:0] out_cnt_r;
  logic [7:0]  out_mask_r;

  // Shared step unit: one entry at ptr_r per cycle
  ostb_pkg::count_t cur_cnt;
  ostb_pkg::count_t cur_tgt;
  logic             wr_en;
  ostb_pkg::count_t wr_cnt;
  ostb_pkg::count_t wr_tgt;
  logic             wr_exp;
  logic             wr_act;
  logic             sweep_op;
  logic             in_xfer;
  logic             resp_load;
  logic [7:0]       mask_now;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign sweep_op  = (op_r == ostb_pkg::OP_TICK) || (op_r == ostb_pkg::OP_CLR_ALL);
  // Build the result once the output register is free or being drained
  assign resp_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  assign cur_cnt = cnt_r[ptr_r];
  assign cur_tgt = tgt_r[ptr_r];

  // One step of the current operation on the entry under the pointer
  always_comb begin
    wr_en  = 1'b0;
    wr_cnt = cur_cnt;
    wr_tgt = cur_tgt;
    wr_exp = exp_r[ptr_r];
    wr_act = act_r[ptr_r];
    if (state_r == S_WORK) begin
      case (op_r)
        ostb_pkg::OP_TICK: begin
          if (act_r[ptr_r]) begin
            wr_en  = 1'b1;
            // Compare before the increment: a match stops the timer
            if (cur_cnt == cur_tgt) begin
              wr_exp = 1'b1;
              wr_act = 1'b0;
            end
            wr_cnt = cur_cnt + ostb_pkg::count_t'(1);
          end
        end
        ostb_pkg::OP_ARM: begin
          wr_en  = idx_ok_r;
          wr_cnt = '0;
          wr_tgt = arm_tgt_r;
          wr_exp = 1'b0;
          wr_act = 1'b1;
        end
        ostb_pkg::OP_CLR_ENTRY: begin
          wr_en  = idx_ok_r;
          wr_cnt = '0;
          wr_tgt = '0;
          wr_exp = 1'b0;
          wr_act = 1'b0;
        end
        ostb_pkg::OP_CLR_ALL: begin
          wr_en  = 1'b1;
          wr_cnt = '0;
          wr_tgt = '0;
          wr_exp = 1'b0;
          wr_act = 1'b0;
        end
        ostb_pkg::OP_CLR_TO: begin
          wr_en  = idx_ok_r;
          wr_exp = 1'b0;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Sequencer: single-entry operations take one step, sweeps visit every timer
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_WORK;
          if ((in_op == ostb_pkg::OP_TICK) || (in_op == ostb_pkg::OP_CLR_ALL)) begin
            ptr_nxt = '0;
          end else begin
            ptr_nxt = ostb_pkg::tidx_t'(in_timer_index);
          end
        end
      end
      S_WORK: begin
        if (!sweep_op || (ptr_r == LAST_IDX)) begin
          state_nxt = S_RESP;
          ptr_nxt   = sel_r;
        end else begin
          ptr_nxt = ptr_r + ostb_pkg::tidx_t'(1);
        end
      end
      S_RESP: begin
        if (resp_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Timeout marks of the first eight timers
  always_comb begin
    mask_now = '0;
    for (int i = 0; i < ostb_pkg::MASK_N; i++) begin
      mask_now[i] = exp_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      exp_r       <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ostb_pkg::NUM_TIMERS; i++) begin
        cnt_r[i] <= '0;
        tgt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      if (wr_en) begin
        cnt_r[ptr_r] <= wr_cnt;
        tgt_r[ptr_r] <= wr_tgt;
        exp_r[ptr_r] <= wr_exp;
        act_r[ptr_r] <= wr_act;
      end
      // Drop the result on transfer, raise it when a new one is loaded
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Captured item and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= in_op;
      sel_r     <= ostb_pkg::tidx_t'(in_timer_index);
      idx_ok_r  <= (32'(in_timer_index) < 32'(ostb_pkg::NUM_TIMERS));
      arm_tgt_r <= ostb_pkg::count_t'(in_target_value);
    end
    if (resp_load) begin
      out_to_r   <= idx_ok_r && exp_r[ptr_r];
      out_run_r  <= idx_ok_r && act_r[ptr_r];
      out_cnt_r  <= idx_ok_r ? 32'(cur_cnt) : 32'd0;
      out_mask_r <= mask_now;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_timeout_flag  = out_to_r;
  assign out_running_flag  = out_run_r;
  assign out_elapsed_count = out_cnt_r;
  assign out_timeout_mask  = out_mask_r;

  // A timer is never both running and timed out
  a_marks_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r & exp_r) == '0)
    else $error("timer running and timed out at once");

  // A single-entry operation goes from the step unit to the result state in the next cycle
  a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WORK && !sweep_op) |=> (state_r == S_RESP))
    else $error("single-entry operation did not finish in one step");

  // An accepted item always starts the step unit
  a_accept_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_WORK))
    else $error("accepted item did not start work");

  // Loading the result returns the sequencer to idle with a valid output
  a_resp_done: assert property (@(posedge clk) disable iff (!rst_n)
    resp_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load did not complete the item");

endmodule

// ===== tb/one_shot_timer_bank_tb.sv =====
// Self-checking testbench for the one-shot timer bank: directed and random operation streams.
`timescale 1ns / 1ps

module one_shot_timer_bank_tb;

  // Codes 6 and 7 have no name in the package; the block answers them as a query
  localparam ostb_pkg::op_t OP_SPARE_A = 3'd6;
  localparam ostb_pkg::op_t OP_SPARE_B = 3'd7;

  localparam int MAX_WAIT    = 14;
  localparam int RANDOM_OPS  = 600;
  localparam int BLOCK_OPS   = 60;
  localparam int DRAIN_WAIT  = ostb_pkg::NUM_TIMERS + 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  // One result transfer as seen on the output channel
  typedef struct packed {
    logic                          timeout;
    logic                          running;
    logic [ostb_pkg::ELAPSE_W-1:0] elapsed;
    logic [ostb_pkg::MASK_W-1:0]   mask;
  } timer_status_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ostb_pkg::OP_W-1:0]     in_op = ostb_pkg::OP_QUERY;
  logic [ostb_pkg::INDEX_W-1:0]  in_timer_index = '0;
  logic [ostb_pkg::TARGET_W-1:0] in_target_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_timeout_flag;
  logic                          out_running_flag;
  logic [ostb_pkg::ELAPSE_W-1:0] out_elapsed_count;
  logic [ostb_pkg::MASK_W-1:0]   out_timeout_mask;

  // Shadow copy of the timer store, updated at every input transfer
  ostb_pkg::count_t shadow_ticks  [ostb_pkg::NUM_TIMERS];
  ostb_pkg::count_t timer_target  [ostb_pkg::NUM_TIMERS];
  logic             timer_expired [ostb_pkg::NUM_TIMERS];
  logic             timer_running [ostb_pkg::NUM_TIMERS];

  timer_status_t pending_status[$];

  // Drop all idle cycles on both sides while set, to get back-to-back transfers
  bit quiet = 1'b0;

  int ops_sent      = 0;
  int results_seen  = 0;
  int expiries_seen = 0;
  int mismatches    = 0;
  int cycle_count   = 0;
  int stall_left    = 0;

  one_shot_timer_bank DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_timer_index    (in_timer_index),
    .in_target_value   (in_target_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_timeout_flag  (out_timeout_flag),
    .out_running_flag  (out_running_flag),
    .out_elapsed_count (out_elapsed_count),
    .out_timeout_mask  (out_timeout_mask)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up on a hung run; the limit sits far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Clear the shadow store to its reset state
  task automatic clear_shadow();
    for (int i = 0; i < ostb_pkg::NUM_TIMERS; i++) begin
      shadow_ticks[i]  = '0;
      timer_target[i]  = '0;
      timer_expired[i] = 1'b0;
      timer_running[i] = 1'b0;
    end
  endtask

  // Apply one operation to the shadow store and queue the status it should report.
  // A tick compares first and counts afterwards, so a timer armed with target T
  // expires on tick T+1.
  task automatic advance_timers(input ostb_pkg::op_t op,
                                input logic [ostb_pkg::INDEX_W-1:0] idx,
                                input logic [ostb_pkg::TARGET_W-1:0] tgt);
    timer_status_t want;
    bit            in_range;
    in_range = (int'(idx) < ostb_pkg::NUM_TIMERS);
    case (op)
      ostb_pkg::OP_TICK: begin
        for (int i = 0; i < ostb_pkg::NUM_TIMERS; i++) begin
          if (timer_running[i]) begin
            if (shadow_ticks[i] == timer_target[i]) begin
              timer_expired[i] = 1'b1;
              timer_running[i] = 1'b0;
              expiries_seen++;
            end
            shadow_ticks[i] = shadow_ticks[i] + ostb_pkg::count_t'(1);
          end
        end
      end
      ostb_pkg::OP_ARM: begin
        if (in_range) begin
          shadow_ticks[idx]  = '0;
          timer_target[idx]  = ostb_pkg::count_t'(tgt);
          timer_expired[idx] = 1'b0;
          timer_running[idx] = 1'b1;
        end
      end
      ostb_pkg::OP_CLR_ENTRY: begin
        if (in_range) begin
          shadow_ticks[idx]  = '0;
          timer_target[idx]  = '0;
          timer_expired[idx] = 1'b0;
          timer_running[idx] = 1'b0;
        end
      end
      ostb_pkg::OP_CLR_ALL: clear_shadow();
      ostb_pkg::OP_CLR_TO: begin
        if (in_range) timer_expired[idx] = 1'b0;
      end
      default: ;
    endcase

    want = '0;
    for (int i = 0; i < ostb_pkg::MASK_N; i++) want.mask[i] = timer_expired[i];
    if (in_range) begin
      want.timeout = timer_expired[idx];
      want.running = timer_running[idx];
      want.elapsed = ostb_pkg::ELAPSE_W'(shadow_ticks[idx]);
    end
    pending_status.push_back(want);
  endtask

  // Send one operation. Hold valid and payload until the transfer, then record
  // the expected status. Valid is only lowered when a gap follows, so a
  // back-to-back item never sees valid dropped and raised in one step.
  task automatic send_op(input ostb_pkg::op_t op,
                         input logic [ostb_pkg::INDEX_W-1:0] idx,
                         input logic [ostb_pkg::TARGET_W-1:0] tgt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_timer_index  <= idx;
    in_target_value <= tgt;
    do @(posedge clk); while (!in_ready);
    advance_timers(op, idx, tgt);
    ops_sent++;
  endtask

  // Lower valid and wait until every queued status has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_status.size() > 0) @(posedge clk);
  endtask

  // Result side: after each transfer draw a random stall, none while quiet is set
  always @(posedge clk) begin : result_sink
    int hold;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      hold = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      stall_left <= hold;
      out_ready  <= (hold == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every result transfer, field by field, with the oldest expectation
  always @(posedge clk) begin : status_check
    timer_status_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] unexpected result: to=%0b run=%0b", $realtime,
                   out_timeout_flag, out_running_flag,
                   " count=%08h mask=%02h", out_elapsed_count, out_timeout_mask);
      end else begin
        want = pending_status.pop_front();
        if (out_timeout_flag !== want.timeout || out_running_flag !== want.running ||
            out_elapsed_count !== want.elapsed || out_timeout_mask !== want.mask) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] result %0d: expected to=%0b run=%0b count=%08h mask=%02h,",
                     $realtime, results_seen, want.timeout, want.running, want.elapsed,
                     want.mask, " got to=%0b run=%0b count=%08h mask=%02h",
                     out_timeout_flag, out_running_flag, out_elapsed_count,
                     out_timeout_mask);
        end
      end
    end
  end

  // Everything reads back as zero straight after reset
  task automatic test_after_reset();
    send_op(ostb_pkg::OP_QUERY, 3'd0, $urandom);
    send_op(ostb_pkg::OP_QUERY, 3'd7, $urandom);
  endtask

  // Arm with target 2: the third tick expires it, then clear the timeout mark
  task automatic test_arm_and_expire();
    send_op(ostb_pkg::OP_ARM, 3'd3, 32'd2);
    repeat (3) send_op(ostb_pkg::OP_TICK, 3'd3, $urandom);
    send_op(ostb_pkg::OP_QUERY, 3'd3, '0);
    send_op(ostb_pkg::OP_CLR_TO, 3'd3, '1);
  endtask

  // Target zero expires on the first tick; the all-ones target never expires here.
  // Re-arm a running timer to restart its count.
  task automatic test_target_extremes();
    send_op(ostb_pkg::OP_ARM, 3'd0, 32'h0000_0000);
    send_op(ostb_pkg::OP_ARM, 3'd7, 32'hFFFF_FFFF);
    send_op(ostb_pkg::OP_TICK, 3'd0, '0);
    send_op(ostb_pkg::OP_QUERY, 3'd7, 32'h5555_AAAA);
    send_op(ostb_pkg::OP_ARM, 3'd7, 32'h8000_0001);
  endtask

  // Clear entry ignores the target field; clear timeout on a timer that never expired;
  // clear all ignores the index but still reports the timer it names
  task automatic test_clears();
    send_op(ostb_pkg::OP_CLR_ENTRY, 3'd0, '1);
    send_op(ostb_pkg::OP_CLR_TO, 3'd5, '0);
    send_op(ostb_pkg::OP_ARM, 3'd5, 32'd1);
    send_op(ostb_pkg::OP_TICK, 3'd6, '1);
    send_op(ostb_pkg::OP_TICK, 3'd5, '0);
    send_op(ostb_pkg::OP_CLR_ALL, 3'd5, $urandom);
    send_op(ostb_pkg::OP_QUERY, 3'd3, '0);
  endtask

  // Unused operation codes change nothing and answer like a query
  task automatic test_spare_codes();
    send_op(ostb_pkg::OP_ARM, 3'd2, 32'd0);
    send_op(OP_SPARE_A, 3'd7, '1);
    send_op(OP_SPARE_B, 3'd2, $urandom);
  endtask

  // Random stream, weighted towards ticks and arms with small targets so that
  // timers keep expiring. Every third block runs without idle cycles.
  task automatic test_random_stream();
    ostb_pkg::op_t                 op;
    logic [ostb_pkg::TARGET_W-1:0] tgt;
    int                            pick;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % BLOCK_OPS == 0) quiet = ((n / BLOCK_OPS) % 3 == 2);
      pick = $urandom_range(0, 99);
      if      (pick < 48) op = ostb_pkg::OP_TICK;
      else if (pick < 70) op = ostb_pkg::OP_ARM;
      else if (pick < 79) op = ostb_pkg::OP_QUERY;
      else if (pick < 86) op = ostb_pkg::OP_CLR_TO;
      else if (pick < 92) op = ostb_pkg::OP_CLR_ENTRY;
      else if (pick < 94) op = ostb_pkg::OP_CLR_ALL;
      else if (pick < 97) op = OP_SPARE_A;
      else                op = OP_SPARE_B;
      tgt = $urandom;
      if (op == ostb_pkg::OP_ARM) begin
        pick = $urandom_range(0, 99);
        if      (pick < 80) tgt = $urandom_range(0, 12);
        else if (pick < 90) tgt = '1;
        else if (pick < 93) tgt = '0;
      end
      send_op(op, ostb_pkg::INDEX_W'($urandom_range(0, 7)), tgt);
    end
    quiet = 1'b0;
  endtask

  initial begin
    clear_shadow();
    // Hold reset, then release it at a clock edge
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_arm_and_expire();
    test_target_extremes();
    test_clears();
    test_spare_codes();
    test_random_stream();

    wait_drained();
    // Let any stray result surface before judging
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d operations, checked %0d results, %0d timer expiries predicted.",
             ops_sent, results_seen, expiries_seen);
    $display("Mismatching results: %0d", mismatches);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
